// ----- hdl/pcrd_pkg.sv -----
// Package for the pinhole camera ray direction core.
// Holds widths, the register index codes, payload and configuration types.
// No dependencies; every other file of the block imports it.
package pcrd_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int MAX_DIMENSION = 4096;

  localparam int DIM_W      = 13;
  localparam int JIT_W      = 16;
  localparam int COMP_W     = 16;
  localparam int VEC_W      = 3 * COMP_W;
  localparam int SCALE_W    = 24;
  localparam int SCALE_FRAC = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VEC_W;

  // Screen mapping: numerator, its product with a scale, quotient width.
  localparam int SCR_W  = 32;
  localparam int PROD_W = SCR_W + SCALE_W;
  localparam int QX_W   = PROD_W - SCALE_FRAC - 1;
  localparam int SX_W   = QX_W + 1;

  // Direction assembly and normalization.
  localparam int BP_W  = SX_W + COMP_W;
  localparam int D_W   = BP_W + 1;
  localparam int MAG_W = D_W - 1;
  localparam int NM_W  = 30;
  localparam int SUM_W = 2 * NM_W + 2;
  localparam int LEN_W = SUM_W / 2;
  localparam int Q_W   = FRACTION_BITS + 1;
  localparam int REM_W = NM_W + FRACTION_BITS + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT,
    CFG_UP,
    CFG_VIEW,
    CFG_ORIGIN,
    CFG_HSCALE,
    CFG_VSCALE,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_index_e;

  typedef struct packed {
    logic [DIM_W-1:0] pixel_column;
    logic [DIM_W-1:0] pixel_row;
    logic [JIT_W-1:0] jitter_x;
    logic [JIT_W-1:0] jitter_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] direction_x;
    logic signed [COMP_W-1:0] direction_y;
    logic signed [COMP_W-1:0] direction_z;
  } out_item_t;

  // Image sizes are held already clamped to the legal range.
  typedef struct packed {
    logic [VEC_W-1:0]   right_vector;
    logic [VEC_W-1:0]   up_vector;
    logic [VEC_W-1:0]   view_vector;
    logic [SCALE_W-1:0] horizontal_scale;
    logic [SCALE_W-1:0] vertical_scale;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } cfg_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] xn;
    logic signed [SCR_W-1:0] yn;
  } screen_t;

  typedef logic [2:0][D_W-1:0] dvec_t;

  function automatic logic signed [COMP_W-1:0] vec_lane(input logic [VEC_W-1:0] v,
                                                       input int k);
    return $signed(v[k*COMP_W +: COMP_W]);
  endfunction

endpackage

// ----- hdl/pcrd_front.sv -----
// Front stage: takes input transfers and forms the signed screen numerators.
// Depends on pcrd_pkg.
module pcrd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcrd_pkg::in_item_t in_item_i,
  input  pcrd_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcrd_pkg::screen_t out_data_o
);
  import pcrd_pkg::*;

  logic    vld_q, vld_d;
  screen_t data_q;
  screen_t data_d;
  logic    take;

  assign in_ready_o = !vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    data_d.xn = $signed({2'b00, in_item_i.pixel_column, in_item_i.jitter_x, 1'b0})
              - $signed({3'b000, cfg_i.image_width, 16'h0000});
    data_d.yn = $signed({3'b000, cfg_i.image_height, 16'h0000})
              - $signed({2'b00, in_item_i.pixel_row, in_item_i.jitter_y, 1'b0});
    if (take) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

// ----- hdl/pcrd_fifo.sv -----
// Short queue between the front stage and the arithmetic pipeline.
// Depends on pcrd_pkg.
module pcrd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pcrd_pkg::screen_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pcrd_pkg::screen_t pop_data_o
);
  import pcrd_pkg::*;

  screen_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o     = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/pcrd_map.sv -----
// Screen mapping pipeline: scales the numerators, divides by the image size
// with one quotient bit per stage, and combines the camera basis.
// Depends on pcrd_pkg.
module pcrd_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pcrd_pkg::screen_t screen_i,
  input  pcrd_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output pcrd_pkg::dvec_t   dir_o
);
  import pcrd_pkg::*;

  localparam int MAP_STG = QX_W + 5;
  localparam int DIVW    = QX_W + DIM_W;

  logic [MAP_STG-1:0]      vld_q;
  logic signed [SCR_W-1:0] scr [2];
  logic [SCALE_W-1:0]      scl [2];
  logic [DIM_W-1:0]        dvs [2];

  logic signed [PROD_W-1:0] pa_q [2];
  logic [QX_W-1:0]          dr_q [QX_W+1][2];
  logic [QX_W-1:0]          dq_q [QX_W+1][2];
  logic                     dn_q [QX_W+1][2];
  logic signed [SX_W-1:0]   sx_q [2];
  logic signed [BP_W-1:0]   pr_q [3];
  logic signed [BP_W-1:0]   pu_q [3];
  logic [D_W-1:0]           d_q  [3];

  assign scr[0] = screen_i.xn;
  assign scr[1] = screen_i.yn;
  assign scl[0] = cfg_i.horizontal_scale;
  assign scl[1] = cfg_i.vertical_scale;
  assign dvs[0] = cfg_i.image_width;
  assign dvs[1] = cfg_i.image_height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[MAP_STG-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[MAP_STG-1];

  for (genvar ch = 0; ch < 2; ch++) begin : g_axis
    logic signed [PROD_W:0] prod;
    logic                   neg;
    logic [PROD_W-1:0]      mag, rnd;
    logic [QX_W:0]          qx;

    assign prod = scr[ch] * $signed({1'b0, scl[ch]});
    assign neg  = pa_q[ch][PROD_W-1];
    assign mag  = neg ? (~pa_q[ch] + 1'b1) : pa_q[ch];
    // Adding half the divisor first makes the floor division round to nearest.
    assign rnd  = mag + {{(PROD_W-DIM_W-15){1'b0}}, dvs[ch], 15'h0000};
    assign qx   = {1'b0, dq_q[QX_W][ch]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[ch]    <= prod[PROD_W-1:0];
        dr_q[0][ch] <= rnd[QX_W+SCALE_FRAC-1:SCALE_FRAC];
        dq_q[0][ch] <= '0;
        dn_q[0][ch] <= neg;
        sx_q[ch]    <= dn_q[QX_W][ch] ? (~qx + 1'b1) : qx;
      end
    end

    for (genvar s = 0; s < QX_W; s++) begin : g_div
      localparam int B = QX_W - 1 - s;
      logic [DIVW-1:0] rem_x, dsh, sub_v;
      logic            ge;

      assign rem_x = {{DIM_W{1'b0}}, dr_q[s][ch]};
      assign dsh   = {{QX_W{1'b0}}, dvs[ch]} << B;
      assign ge    = rem_x >= dsh;
      assign sub_v = rem_x - dsh;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dr_q[s+1][ch] <= ge ? sub_v[QX_W-1:0] : dr_q[s][ch];
          dq_q[s+1][ch] <= dq_q[s][ch] | (ge ? (QX_W'(1) << B) : '0);
          dn_q[s+1][ch] <= dn_q[s][ch];
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic signed [COMP_W-1:0] vl;

    assign vl = vec_lane(cfg_i.view_vector, c);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr_q[c] <= sx_q[0] * vec_lane(cfg_i.right_vector, c);
        pu_q[c] <= sx_q[1] * vec_lane(cfg_i.up_vector, c);
        d_q[c]  <= {pr_q[c][BP_W-1], pr_q[c]} + {pu_q[c][BP_W-1], pu_q[c]}
                 + {{(D_W-COMP_W-16){vl[COMP_W-1]}}, vl, 16'h0000};
      end
    end

    assign dir_o[c] = d_q[c];
  end

endmodule

// ----- hdl/pcrd_unit.sv -----
// Normalization pipeline: block scaling, sum of squares, a square root with
// one result bit per stage and a per-component divide with one bit per stage.
// Depends on pcrd_pkg.
module pcrd_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pcrd_pkg::dvec_t     dir_i,
  output logic                valid_o,
  output pcrd_pkg::out_item_t item_o
);
  import pcrd_pkg::*;

  localparam int NRM_STG  = 6;
  localparam int SQ_STG   = LEN_W;
  localparam int UNIT_STG = 1 + NRM_STG + 2 + SQ_STG + 1 + Q_W + 1;

  logic [UNIT_STG-1:0] vld_q;
  // Sign of each component and the zero-direction flag travel alongside.
  logic [3:0]          side_q [UNIT_STG-1];
  logic [2:0]          ng0;
  logic [2:0]          nz0;

  logic [MAG_W-1:0]   mg_q  [NRM_STG+1][3];
  logic [NM_W-1:0]    nm_q  [SQ_STG+2][3];
  logic [2*NM_W-1:0]  sq_q  [3];
  logic [SUM_W-1:0]   x_q   [SQ_STG+1];
  logic [SUM_W-1:0]   rs_q  [SQ_STG+1];
  logic [LEN_W-1:0]   len_q [Q_W+1];
  logic [REM_W-1:0]   rm_q  [Q_W+1][3];
  logic [Q_W-1:0]     qo_q  [Q_W+1][3];
  logic [COMP_W-1:0]  out_q [3];
  logic [LEN_W-1:0]   len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[UNIT_STG-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[UNIT_STG-1];

  for (genvar c = 0; c < 3; c++) begin : g_in
    logic [D_W-1:0] dneg;

    assign ng0[c] = dir_i[c][D_W-1];
    assign nz0[c] = dir_i[c] != '0;
    assign dneg   = ~dir_i[c] + 1'b1;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mg_q[0][c] <= ng0[c] ? dneg[MAG_W-1:0] : dir_i[c][MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= {~|nz0, ng0};
      for (int k = 1; k < UNIT_STG - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // All three magnitudes share one shift, chosen from their common leading one.
  for (genvar k = 0; k < NRM_STG; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic [MAG_W-1:0] ow;
    logic             take;

    assign ow   = mg_q[k][0] | mg_q[k][1] | mg_q[k][2];
    assign take = ow[MAG_W-1 -: SH] == '0;

    for (genvar c = 0; c < 3; c++) begin : g_c
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mg_q[k+1][c] <= take ? (mg_q[k][c] << SH) : mg_q[k][c];
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_sq
    logic [NM_W-1:0] nm;

    assign nm = mg_q[NRM_STG][c][MAG_W-1 -: NM_W];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[c]    <= nm * nm;
        nm_q[0][c] <= nm;
        for (int k = 1; k < SQ_STG + 2; k++) begin
          nm_q[k][c] <= nm_q[k-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
      rs_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sqrt
    localparam int BS = SUM_W - 2 - 2 * k;
    localparam logic [SUM_W:0] BITV = {{SUM_W{1'b0}}, 1'b1} << BS;
    logic [SUM_W:0] trial, xdiff, rnext;
    logic           ge;

    assign trial = {1'b0, rs_q[k]} + BITV;
    assign ge    = {1'b0, x_q[k]} >= trial;
    assign xdiff = {1'b0, x_q[k]} - trial;
    assign rnext = ({1'b0, rs_q[k]} >> 1) + BITV;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]  <= ge ? xdiff[SUM_W-1:0] : x_q[k];
        rs_q[k+1] <= ge ? rnext[SUM_W-1:0] : (rs_q[k] >> 1);
      end
    end
  end

  assign len = rs_q[SQ_STG][LEN_W-1:0];

  for (genvar c = 0; c < 3; c++) begin : g_num
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rm_q[0][c] <= {2'b00, nm_q[SQ_STG+1][c], {FRACTION_BITS{1'b0}}}
                    + REM_W'(len >> 1);
        qo_q[0][c] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0] <= len;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int B = Q_W - 1 - j;
    logic [REM_W-1:0] dsh;

    assign dsh = REM_W'(len_q[j]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[j+1] <= len_q[j];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_c
      logic ge;

      assign ge = rm_q[j][c] >= dsh;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rm_q[j+1][c] <= ge ? (rm_q[j][c] - dsh) : rm_q[j][c];
          qo_q[j+1][c] <= qo_q[j][c] | (ge ? (Q_W'(1) << B) : '0);
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_out
    logic [COMP_W-1:0] qv;

    assign qv = {1'b0, qo_q[Q_W][c]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (side_q[UNIT_STG-2][3]) begin
          out_q[c] <= '0;
        end else begin
          out_q[c] <= side_q[UNIT_STG-2][c] ? (~qv + 1'b1) : qv;
        end
      end
    end
  end

  assign item_o.direction_x = $signed(out_q[0]);
  assign item_o.direction_y = $signed(out_q[1]);
  assign item_o.direction_z = $signed(out_q[2]);

endmodule

// ----- hdl/pinhole_camera_ray_direction_core.sv -----
// Pinhole camera primary ray direction core, top level.
// Depends on pcrd_pkg, pcrd_front, pcrd_fifo, pcrd_map and pcrd_unit.
//
// Input transfers carry a pixel column, a pixel row and two Q0.16 jitter
// fractions; output transfers carry the normalized direction as three Q1.14
// components. Both channels use valid and ready.
// The configuration port writes one register per cycle with cfg_we_i; it is
// meant to be used only while no ray is in flight.
// Throughput is one ray per clock while the receiver does not stall. The path
// runs through the front register, the queue, 44 mapping stages (39 of them one
// quotient bit each of the image size division) and 57 normalization stages (31
// square root bits and 15 quotient bits of the final division).
// The front accepts items into a four-entry queue independently of the
// output. When the receiver stalls, the arithmetic pipeline holds and the
// queue fills; input ready drops only once the queue and front are full.
// Reset empties the pipeline and queue and loads the default camera: right
// along x, up along y, view along -z, unit scales, 1024 by 1024 pixels.
module pinhole_camera_ray_direction_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pcrd_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pcrd_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [pcrd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcrd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pcrd_pkg::*;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIMENSION);

  logic [VEC_W-1:0]   right_q, up_q, view_q;
  logic [SCALE_W-1:0] hscale_q, vscale_q;
  logic [DIM_W-1:0]   width_q, height_q;
  cfg_t               cfg;

  logic    fr_valid, fifo_full, fifo_empty, en, pop, map_valid;
  screen_t fr_data, fifo_data;
  dvec_t   map_dir;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q  <= VEC_W'(48'h0000_0000_4000);
      up_q     <= VEC_W'(48'h0000_4000_0000);
      view_q   <= VEC_W'(48'hC000_0000_0000);
      hscale_q <= SCALE_W'(24'h01_0000);
      vscale_q <= SCALE_W'(24'h01_0000);
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_RIGHT:  right_q  <= cfg_data_i;
        CFG_UP:     up_q     <= cfg_data_i;
        CFG_VIEW:   view_q   <= cfg_data_i;
        CFG_ORIGIN: ; // The origin does not enter the direction.
        CFG_HSCALE: hscale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_VSCALE: vscale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
      endcase
    end
  end

  // A zero size acts as one pixel, and sizes beyond the maximum are clamped.
  always_comb begin
    cfg.right_vector     = right_q;
    cfg.up_vector        = up_q;
    cfg.view_vector      = view_q;
    cfg.horizontal_scale = hscale_q;
    cfg.vertical_scale   = vscale_q;
    cfg.image_width      = (width_q == '0) ? DIM_W'(1) :
                           ((width_q > MAX_DIM_C) ? MAX_DIM_C : width_q);
    cfg.image_height     = (height_q == '0) ? DIM_W'(1) :
                           ((height_q > MAX_DIM_C) ? MAX_DIM_C : height_q);
  end

  pcrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .out_valid_o(fr_valid),
    .out_ready_i(!fifo_full),
    .out_data_o (fr_data)
  );

  pcrd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fr_valid),
    .push_data_i(fr_data),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .empty_o    (fifo_empty),
    .pop_data_o (fifo_data)
  );

  // The back pipeline advances whenever the output register is free or drains.
  assign en  = !out_valid_o || out_ready_i;
  assign pop = en && !fifo_empty;

  pcrd_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop),
    .screen_i(fifo_data),
    .cfg_i   (cfg),
    .valid_o (map_valid),
    .dir_o   (map_dir)
  );

  pcrd_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(map_valid),
    .dir_i  (map_dir),
    .valid_o(out_valid_o),
    .item_o (out_item_o)
  );

endmodule

// ----- bench/tb_pinhole_camera_ray_direction_core.sv -----
// Testbench for the pinhole camera ray direction core.
// Predicts each normalized ray direction in integer arithmetic and checks
// every output transfer against it. Depends on pcrd_pkg and the core RTL.
module tb_pinhole_camera_ray_direction_core;
  import pcrd_pkg::*;

  localparam int LATENCY = 110;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_item_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pinhole_camera_ray_direction_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // Camera state as the predictor sees it.
  logic [47:0] cam_right, cam_up, cam_view, cam_origin;
  logic [23:0] cam_hscale, cam_vscale;
  logic [12:0] cam_width, cam_height;

  in_item_t  pending_rays[$];
  out_item_t expected_dirs[$];
  int errors;
  longint cycles;
  bit calm;  // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic longint comp_of(input logic [47:0] v, input int k);
    logic signed [15:0] c;
    c = v[k*16 +: 16];
    return longint'(c);
  endfunction

  function automatic longint eff_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return longint'(v);
  endfunction

  function automatic longint rnd_div(input longint n, input longint d);
    longint m;
    m = (n < 0) ? -n : n;
    m = (m + d / 2) / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic out_item_t ray_direction(input in_item_t it);
    longint w, h, xn, yn, sx, sy, d, top, len;
    longint unsigned mag[3], sum, q;
    bit neg[3];
    logic [15:0] res[3];
    out_item_t o;
    w = eff_dim(cam_width);
    h = eff_dim(cam_height);
    xn = 2 * (longint'(it.pixel_column) * 65536 + longint'(it.jitter_x)) - w * 65536;
    yn = h * 65536 - 2 * (longint'(it.pixel_row) * 65536 + longint'(it.jitter_y));
    sx = rnd_div(xn * longint'(cam_hscale), w * 65536);
    sy = rnd_div(yn * longint'(cam_vscale), h * 65536);
    top = 0;
    for (int c = 0; c < 3; c++) begin
      d = sx * comp_of(cam_right, c) + sy * comp_of(cam_up, c)
          + comp_of(cam_view, c) * 65536;
      neg[c] = d < 0;
      mag[c] = neg[c] ? -d : d;
      if (mag[c] > top) top = mag[c];
    end
    if (top == 0) return '0;
    // Block scaling puts the largest magnitude into [2^29, 2^30).
    while (top >= (64'd1 << 30)) begin
      for (int c = 0; c < 3; c++) mag[c] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int c = 0; c < 3; c++) mag[c] <<= 1;
      top <<= 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sum);
    for (int c = 0; c < 3; c++) begin
      q = ((mag[c] << FRACTION_BITS) + len / 2) / len;
      res[c] = neg[c] ? 16'(-q) : 16'(q);
    end
    o.direction_x = res[0];
    o.direction_y = res[1];
    o.direction_z = res[2];
    return o;
  endfunction

  // Driver: take from the pending queue; hold valid and payload until transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_dirs.push_back(ray_direction(in_item_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_rays.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          in_item_i <= pending_rays.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and in-order compare.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_dir;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || $urandom_range(99) >= 22;
      if (out_valid_o && out_ready_i) begin
        if (expected_dirs.size() == 0) begin
          $error("unexpected output transfer %h", out_item_o);
          errors++;
        end else begin
          exp_dir = expected_dirs.pop_front();
          if (out_item_o.direction_x !== exp_dir.direction_x) begin
            $error("direction_x expected %0d got %0d", exp_dir.direction_x,
                   out_item_o.direction_x);
            errors++;
          end
          if (out_item_o.direction_y !== exp_dir.direction_y) begin
            $error("direction_y expected %0d got %0d", exp_dir.direction_y,
                   out_item_o.direction_y);
            errors++;
          end
          if (out_item_o.direction_z !== exp_dir.direction_z) begin
            $error("direction_z expected %0d got %0d", exp_dir.direction_z,
                   out_item_o.direction_z);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_index_e idx, input logic [47:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RIGHT:  cam_right = value;
      CFG_UP:     cam_up = value;
      CFG_VIEW:   cam_view = value;
      CFG_ORIGIN: cam_origin = value;
      CFG_HSCALE: cam_hscale = value[23:0];
      CFG_VSCALE: cam_vscale = value[23:0];
      CFG_WIDTH:  cam_width = value[12:0];
      default:    cam_height = value[12:0];
    endcase
  endtask

  task automatic drain_pipe();
    while (pending_rays.size() != 0 || in_valid_i || expected_dirs.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic in_item_t make_ray(input int col, input int row, input int jx,
                                        input int jy);
    in_item_t it;
    it.pixel_column = 13'(col);
    it.pixel_row = 13'(row);
    it.jitter_x = 16'(jx);
    it.jitter_y = 16'(jy);
    return it;
  endfunction

  // Random unit-ish Q1.14 vector, sometimes full random bits.
  function automatic logic [47:0] rand_vec();
    logic [47:0] v;
    if ($urandom_range(3) == 0) v = 48'({$urandom(), $urandom()});
    else begin
      for (int c = 0; c < 3; c++) v[c*16 +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    end
    return v;
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(5))
      0: return $urandom_range(8191);
      1: return $urandom_range(1, 4);
      2: return 4096;
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  task automatic random_rays(input int count);
    int w, h, col, row;
    w = int'(eff_dim(cam_width));
    h = int'(eff_dim(cam_height));
    for (int i = 0; i < count; i++) begin
      col = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(w);
      row = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(h);
      pending_rays.push_back(make_ray(col, row, $urandom_range(65535),
                                      $urandom_range(65535)));
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    cam_right = 48'd16384;
    cam_up = 48'd1073741824;
    cam_view = 48'd211106232532992;
    cam_origin = '0;
    cam_hscale = 24'd65536;
    cam_vscale = 24'd65536;
    cam_width = 13'd1024;
    cam_height = 13'd1024;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, edge rays, extreme jitter, pixels beyond the image.
    pending_rays.push_back(make_ray(0, 0, 0, 0));
    pending_rays.push_back(make_ray(1024, 1024, 0, 0));
    pending_rays.push_back(make_ray(512, 512, 0, 0));
    pending_rays.push_back(make_ray(1023, 1023, 65535, 65535));
    pending_rays.push_back(make_ray(8191, 8191, 65535, 65535));
    pending_rays.push_back(make_ray(0, 8191, 32768, 0));
    pending_rays.push_back(make_ray(4096, 0, 65535, 32768));
    pending_rays.push_back(make_ray(5461, 2730, 21845, 43690));
    drain_pipe();

    // Degenerate direction: center pixel with a zero view vector.
    write_reg(CFG_VIEW, 48'd0);
    pending_rays.push_back(make_ray(512, 512, 0, 0));
    pending_rays.push_back(make_ray(0, 1024, 0, 0));
    drain_pipe();

    // Zero size, oversized size, extreme scales and full-range vectors.
    write_reg(CFG_WIDTH, 48'd0);
    write_reg(CFG_HEIGHT, 48'h1fff);
    write_reg(CFG_HSCALE, 48'hff_ffffff);
    write_reg(CFG_VSCALE, 48'd0);
    write_reg(CFG_RIGHT, 48'h8000_8000_8000);
    write_reg(CFG_UP, 48'h7fff_7fff_7fff);
    write_reg(CFG_VIEW, 48'h8000_7fff_8000);
    write_reg(CFG_ORIGIN, 48'hffff_ffff_ffff);
    pending_rays.push_back(make_ray(0, 0, 0, 0));
    pending_rays.push_back(make_ray(1, 4096, 65535, 65535));
    pending_rays.push_back(make_ray(8191, 0, 1, 1));
    pending_rays.push_back(make_ray(0, 8191, 0, 65535));
    drain_pipe();
    write_reg(CFG_VSCALE, 48'hff_ffffff);
    write_reg(CFG_HSCALE, 48'd0);
    pending_rays.push_back(make_ray(8191, 8191, 65535, 0));
    pending_rays.push_back(make_ray(3, 2048, 4, 5));
    drain_pipe();

    // Random phases, each with its own camera; one phase runs without idling.
    for (int phase = 0; phase < 14; phase++) begin
      write_reg(CFG_RIGHT, rand_vec());
      write_reg(CFG_UP, rand_vec());
      write_reg(CFG_VIEW, rand_vec());
      write_reg(CFG_ORIGIN, 48'({$urandom(), $urandom()}));
      write_reg(CFG_HSCALE,
                48'($urandom_range(3) == 0 ? $urandom() : $urandom_range(200000)));
      write_reg(CFG_VSCALE,
                48'($urandom_range(3) == 0 ? $urandom() : $urandom_range(200000)));
      write_reg(CFG_WIDTH, 48'(rand_dim()));
      write_reg(CFG_HEIGHT, 48'(rand_dim()));
      calm = (phase == 5);
      random_rays(125);
      drain_pipe();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pcrd_pkg.sv
hdl/pcrd_front.sv
hdl/pcrd_fifo.sv
hdl/pcrd_map.sv
hdl/pcrd_unit.sv
hdl/pinhole_camera_ray_direction_core.sv
bench/tb_pinhole_camera_ray_direction_core.sv
